// ===== hdl/taf_pkg.sv =====
package taf_pkg;

    // Fixed field widths
    localparam int unsigned POS_W    = 20;
    localparam int unsigned ABS_W    = 20;
    localparam int unsigned SQ_W     = 2 * ABS_W;
    localparam int unsigned RAD_W    = 42;
    localparam int unsigned ROOT_W   = 21;
    localparam int unsigned REM_W    = 24;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned AVG_W    = 21;
    localparam int unsigned THR_W    = 24;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 3;

    // Microprogram geometry
    localparam int unsigned PC_W      = 4;
    localparam int unsigned ITER_W    = 6;
    localparam int unsigned ROOT_STEPS = RAD_W / 2;
    localparam int unsigned DIV_STEPS  = SUM_W;

    // Register index of the threshold
    localparam logic REG_THRESHOLD = 1'b0;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_RAD,
        OP_ROOT,
        OP_ACC,
        OP_DINIT,
        OP_DIV,
        OP_FIN
    } op_t;

    // Sequencing codes
    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_WAIT_IN,
        SQ_LOOP,
        SQ_BR_MORE,
        SQ_WAIT_OUT,
        SQ_JUMP
    } seq_t;

    typedef struct packed {
        op_t               op;
        seq_t              seq;
        logic [PC_W-1:0]   target;
        logic              ld_iter;
        logic [ITER_W-1:0] iter_val;
    } uword_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic last;
        logic out_free;
    } stat_t;

    // Control from sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic act;
        logic take_in;
    } ctrl_t;

    // Microprogram store
    function automatic uword_t ucode(input logic [PC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_SQX, seq: SQ_JUMP, target: '0, ld_iter: 1'b0, iter_val: '0};
        case (addr)
            4'd0: w = '{OP_LOAD,  SQ_WAIT_IN,  4'd0, 1'b0, '0};
            4'd1: w = '{OP_SQX,   SQ_NEXT,     4'd0, 1'b0, '0};
            4'd2: w = '{OP_SQY,   SQ_NEXT,     4'd0, 1'b0, '0};
            4'd3: w = '{OP_RAD,   SQ_NEXT,     4'd0, 1'b1, ITER_W'(ROOT_STEPS)};
            4'd4: w = '{OP_ROOT,  SQ_LOOP,     4'd0, 1'b0, '0};
            4'd5: w = '{OP_ACC,   SQ_BR_MORE,  4'd0, 1'b0, '0};
            4'd6: w = '{OP_DINIT, SQ_NEXT,     4'd0, 1'b1, ITER_W'(DIV_STEPS)};
            4'd7: w = '{OP_DIV,   SQ_LOOP,     4'd0, 1'b0, '0};
            4'd8: w = '{OP_FIN,   SQ_WAIT_OUT, 4'd0, 1'b0, '0};
            default: w = '{op: OP_SQX, seq: SQ_JUMP, target: '0, ld_iter: 1'b0,
                           iter_val: '0};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/track_average_step_filter.sv =====
// Track average step filter.
// Points arrive on the pt channel (pos_x, pos_y, last_of_track) with
// pt_valid / pt_stall; a transaction completes when valid is high and
// stall is low. One result per track leaves on the res channel
// (average_step, step_defined, keep_track) with res_valid / res_stall.
// The threshold register sits at byte address 0 of the APB port.
// Sequence: a point occupies the block for the load, one multiplier
// pass per axis, a radicand add, a bit-serial square root and the
// accumulate, all stepped by the microprogram. A final point adds the
// restoring divide and the result load before res_valid rises; the next
// point is taken once the result is loaded. pt_stall is low only at the
// program's input step. When the receiver stalls, the result stays in
// the output register and the next point is still taken; a later result
// waits at the final step until the register frees. Reset clears the
// track state, the threshold and the output valid; the block is ready
// for a point straight after.
module track_average_step_filter #(
    parameter int unsigned MAX_STEPS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [taf_pkg::ADDR_W-1:0]    paddr,
    input  logic [taf_pkg::DATA_W-1:0]    pwdata,
    output logic [taf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          pt_valid,
    output logic                          pt_stall,
    input  logic signed [taf_pkg::POS_W-1:0] pos_x,
    input  logic signed [taf_pkg::POS_W-1:0] pos_y,
    input  logic                          last_of_track,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [taf_pkg::AVG_W-1:0]     average_step,
    output logic                          step_defined,
    output logic                          keep_track
);
    import taf_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);

    stat_t stat;
    ctrl_t ctrl;

    logic [THR_W-1:0]        thr_reg;
    logic [POS_W-1:0]        prev_x_reg;
    logic [POS_W-1:0]        prev_y_reg;
    logic                    have_prev_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    last_reg;
    logic                    step_ok_reg;
    logic [ABS_W-1:0]        ax_reg;
    logic [ABS_W-1:0]        ay_reg;
    logic [SQ_W-1:0]         prod_reg;
    logic [SQ_W-1:0]         sqa_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [REM_W-3:0]        rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        drem_reg;
    logic                    res_valid_reg;
    logic [AVG_W-1:0]        avg_reg;
    logic                    def_reg;
    logic                    keep_reg;

    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic [POS_W:0]          dx_abs;
    logic [POS_W:0]          dy_abs;
    logic [ABS_W-1:0]        mul_in;
    logic [SQ_W-1:0]         mul_out;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        trial;
    logic                    root_bit;
    logic [CNT_W:0]          drem_sh;
    logic                    quo_bit;
    logic                    cfg_wr;
    logic                    out_free;

    // Sequencer
    assign stat.in_valid = pt_valid;
    assign stat.last     = last_reg;
    assign stat.out_free = out_free;

    taf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign pt_stall = !ctrl.take_in;
    assign out_free = !res_valid_reg || !res_stall;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_THRESHOLD))
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // Coordinate differences, magnitudes
    assign dx     = {pos_x[POS_W-1], pos_x} - {prev_x_reg[POS_W-1], prev_x_reg};
    assign dy     = {pos_y[POS_W-1], pos_y} - {prev_y_reg[POS_W-1], prev_y_reg};
    assign dx_abs = dx[POS_W] ? -dx : dx;
    assign dy_abs = dy[POS_W] ? -dy : dy;

    // Shared multiplier
    assign mul_in  = (ctrl.op == OP_SQX) ? ax_reg : ay_reg;
    assign mul_out = mul_in * mul_in;

    // Square root digit step
    assign rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign root_bit = (rem_sh >= trial);

    // Divide digit step
    assign drem_sh = {drem_reg, quo_reg[SUM_W-1]};
    assign quo_bit = (drem_sh >= {1'b0, cnt_reg});

    // Track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            step_ok_reg   <= 1'b0;
        end
        else if (ctrl.act)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    prev_x_reg    <= pos_x;
                    prev_y_reg    <= pos_y;
                    have_prev_reg <= 1'b1;
                    last_reg      <= last_of_track;
                    step_ok_reg   <= have_prev_reg && (cnt_reg < CNT_W'(MAX_STEPS));
                end
                OP_ACC:
                begin
                    if (step_ok_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(root_reg);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                OP_FIN:
                begin
                    prev_x_reg    <= '0;
                    prev_y_reg    <= '0;
                    have_prev_reg <= 1'b0;
                    sum_reg       <= '0;
                    cnt_reg       <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.act)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    ax_reg <= dx_abs[ABS_W-1:0];
                    ay_reg <= dy_abs[ABS_W-1:0];
                end
                OP_SQX:
                begin
                    prod_reg <= mul_out;
                end
                OP_SQY:
                begin
                    sqa_reg  <= prod_reg;
                    prod_reg <= mul_out;
                end
                OP_RAD:
                begin
                    rad_reg  <= RAD_W'(sqa_reg) + RAD_W'(prod_reg);
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                OP_ROOT:
                begin
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    rem_reg  <= root_bit ? (REM_W-2)'(rem_sh - trial)
                                         : rem_sh[REM_W-3:0];
                    root_reg <= {root_reg[ROOT_W-2:0], root_bit};
                end
                OP_DINIT:
                begin
                    quo_reg  <= sum_reg;
                    drem_reg <= '0;
                end
                OP_DIV:
                begin
                    quo_reg  <= {quo_reg[SUM_W-2:0], quo_bit};
                    drem_reg <= quo_bit ? CNT_W'(drem_sh - {1'b0, cnt_reg})
                                        : drem_sh[CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.act && (ctrl.op == OP_FIN))
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.act && (ctrl.op == OP_FIN))
        begin
            def_reg  <= (cnt_reg != '0);
            avg_reg  <= (cnt_reg != '0) ? quo_reg[AVG_W-1:0] : '0;
            keep_reg <= (cnt_reg != '0) && (quo_reg >= SUM_W'(thr_reg));
        end
    end

    assign res_valid    = res_valid_reg;
    assign average_step = avg_reg;
    assign step_defined = def_reg;
    assign keep_track   = keep_reg;

endmodule

// ===== hdl/taf_seq.sv =====
module taf_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  taf_pkg::stat_t stat,
    output taf_pkg::ctrl_t ctrl
);
    import taf_pkg::*;

    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    uword_t            uw;

    // Fetch the current control word
    assign uw = ucode(pc_reg);

    // Step counter and loop counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            iter_reg <= '0;
        end
        else
        begin
            pc_reg   <= pc_next;
            iter_reg <= iter_next;
        end
    end

    // Next step, loop count and datapath enables
    always_comb
    begin
        pc_next      = pc_reg + 1'b1;
        iter_next    = iter_reg;
        ctrl.op      = uw.op;
        ctrl.act     = 1'b1;
        ctrl.take_in = 1'b0;
        if (uw.ld_iter)
        begin
            iter_next = uw.iter_val;
        end
        case (uw.seq)
            SQ_NEXT:
            begin
                pc_next = pc_reg + 1'b1;
            end
            SQ_WAIT_IN:
            begin
                ctrl.take_in = 1'b1;
                ctrl.act     = stat.in_valid;
                if (!stat.in_valid)
                begin
                    pc_next = pc_reg;
                end
            end
            SQ_LOOP:
            begin
                iter_next = iter_reg - 1'b1;
                if (iter_reg != ITER_W'(1))
                begin
                    pc_next = pc_reg;
                end
            end
            SQ_BR_MORE:
            begin
                if (!stat.last)
                begin
                    pc_next = uw.target;
                end
            end
            SQ_WAIT_OUT:
            begin
                ctrl.act = stat.out_free;
                pc_next  = stat.out_free ? uw.target : pc_reg;
            end
            SQ_JUMP:
            begin
                ctrl.act = 1'b0;
                pc_next  = uw.target;
            end
            default:
            begin
                ctrl.act = 1'b0;
                pc_next  = '0;
            end
        endcase
    end

endmodule
